>>> rtl/dmsc_pkg.sv
// Shared constants for the djb2 serial check block.
package dmsc_pkg;

  localparam int unsigned HashW = 64;
  localparam int unsigned SeedW = 32;
  localparam int unsigned ByteW = 8;

  localparam logic [HashW-1:0] HashStart = 64'd5381;
  localparam logic [HashW-1:0] MixMul    = 64'h9ddfea08eb382d69;
  localparam int unsigned      MixShift  = 47;
  localparam int unsigned      HalfW     = 32;
  localparam int unsigned      Mul33Shift = 5;

  // configuration register indexes
  localparam logic CfgSeed     = 1'b0;
  localparam logic CfgExpected = 1'b1;

endpackage

>>> rtl/dmsc_front.sv
// Front end: folds name bytes into the djb2 running hash, hands off on the final byte.
module dmsc_front import dmsc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [ByteW-1:0] name_byte_i,
  input  logic             final_byte_i,
  output logic             hand_valid_o,
  output logic [HashW-1:0] hand_hash_o
);

  logic [HashW-1:0] hash_q, hash_d;
  logic [HashW-1:0] hash_nxt;
  logic [HashW-1:0] byte_ext;

  assign byte_ext = {{(HashW-ByteW){name_byte_i[ByteW-1]}}, name_byte_i};
  // hash*33 + byte
  assign hash_nxt = (hash_q << Mul33Shift) + hash_q + byte_ext;

  always_comb begin
    hash_d = hash_q;
    if (accept_i) begin
      hash_d = final_byte_i ? HashStart : hash_nxt;
    end
  end

  assign hand_valid_o = accept_i && final_byte_i;
  assign hand_hash_o  = hash_nxt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= HashStart;
    end else begin
      hash_q <= hash_d;
    end
  end

endmodule

>>> rtl/dmsc_queue.sv
// Short queue of finished name hashes between front and mixer.
module dmsc_queue import dmsc_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [HashW-1:0] wr_data_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic             valid_o,
  output logic [HashW-1:0] rd_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [HashW-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wp_q, wp_d, rp_q, rp_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o    = (cnt_q == FullCnt);
  assign valid_o   = (cnt_q != '0);
  assign rd_data_o = mem_q[rp_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (do_wr) begin
      wp_d = (wp_q == LastPtr) ? '0 : wp_q + 1'b1;
    end
    if (do_rd) begin
      rp_d = (rp_q == LastPtr) ? '0 : rp_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wp_q] <= wr_data_i;
    end
  end

endmodule

>>> rtl/dmsc_mix.sv
// Back end: 128-to-64 multiply-xorshift mix on a shared 32x32 multiplier, result register.
module dmsc_mix import dmsc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  logic [HashW-1:0] q_hash_i,
  output logic             q_pop_o,
  input  logic [SeedW-1:0] seed_i,
  input  logic [HashW-1:0] expected_i,
  output logic             empty_o,
  input  logic             pop_i,
  output logic [HashW-1:0] serial_value_o,
  output logic             is_match_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMul  = 2'd1;
  localparam logic [1:0] StXs   = 2'd2;
  localparam logic [1:0] StFin  = 2'd3;

  localparam logic [1:0] LastSub  = 2'd2;
  localparam logic [1:0] PassA    = 2'd0;
  localparam logic [1:0] PassB    = 2'd1;

  logic [1:0]       st_q, st_d;
  logic [1:0]       sub_q, sub_d;
  logic [1:0]       pass_q, pass_d;
  logic [HashW-1:0] x_q, x_d;
  logic [HashW-1:0] h_q, h_d;
  logic [HashW-1:0] acc_q, acc_d;
  logic             ov_q, ov_d;
  logic [HashW-1:0] ser_q, ser_d;
  logic             match_q, match_d;

  logic [HashW-1:0]   seed_word;
  logic [HalfW-1:0]   op_a, op_b;
  logic [2*HalfW-1:0] prod;
  logic [HashW-1:0]   acc_xs;
  logic               out_free;

  assign seed_word = {seed_i | {SeedW{seed_i[SeedW-1]}}, seed_i};
  assign acc_xs    = acc_q ^ (acc_q >> MixShift);
  assign out_free  = !ov_q || pop_i;

  // low 64 bits of x*K from three 32x32 partial products, one per cycle
  always_comb begin
    unique case (sub_q)
      2'd0:    begin op_a = x_q[HalfW-1:0];     op_b = MixMul[HalfW-1:0];     end
      2'd1:    begin op_a = x_q[HalfW-1:0];     op_b = MixMul[HashW-1:HalfW]; end
      default: begin op_a = x_q[HashW-1:HalfW]; op_b = MixMul[HalfW-1:0];     end
    endcase
  end
  assign prod = op_a * op_b;

  always_comb begin
    st_d    = st_q;
    sub_d   = sub_q;
    pass_d  = pass_q;
    x_d     = x_q;
    h_d     = h_q;
    acc_d   = acc_q;
    ov_d    = ov_q;
    ser_d   = ser_q;
    match_d = match_q;
    q_pop_o = 1'b0;
    if (pop_i && ov_q) begin
      ov_d = 1'b0;
    end
    unique case (st_q)
      StIdle: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          h_d     = q_hash_i;
          x_d     = q_hash_i ^ seed_word;
          sub_d   = '0;
          pass_d  = PassA;
          st_d    = StMul;
        end
      end
      StMul: begin
        if (sub_q == '0) begin
          acc_d = prod;
        end else begin
          acc_d = acc_q + {prod[HalfW-1:0], {HalfW{1'b0}}};
        end
        if (sub_q == LastSub) begin
          sub_d = '0;
          st_d  = StXs;
        end else begin
          sub_d = sub_q + 1'b1;
        end
      end
      StXs: begin
        priority if (pass_q == PassA) begin
          x_d    = h_q ^ acc_xs;
          pass_d = PassB;
          st_d   = StMul;
        end else if (pass_q == PassB) begin
          x_d    = acc_xs;
          pass_d = pass_q + 1'b1;
          st_d   = StMul;
        end else begin
          st_d = StFin;
        end
      end
      default: begin
        // acc holds the serial; wait for a free output word
        if (out_free) begin
          ov_d    = 1'b1;
          ser_d   = acc_q;
          match_d = (acc_q == expected_i);
          st_d    = StIdle;
        end
      end
    endcase
  end

  assign empty_o        = !ov_q;
  assign serial_value_o = ser_q;
  assign is_match_o     = match_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= StIdle;
      sub_q  <= '0;
      pass_q <= PassA;
      ov_q   <= 1'b0;
    end else begin
      st_q   <= st_d;
      sub_q  <= sub_d;
      pass_q <= pass_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    h_q     <= h_d;
    acc_q   <= acc_d;
    ser_q   <= ser_d;
    match_q <= match_d;
  end

endmodule

>>> rtl/djb2_mix_serial_check.sv
// Path: the final byte's hash is queued, mixed, then registered as a poppable serial word.
// Throughput: one name byte per cycle while the queue is not full; the mixer takes
//   one name at a time (three 64-bit multiplies of three 32x32 passes each, plus xorshifts).
// A QueueDepth-entry hash queue lets the byte stream run ahead of the mixer.
// Reset: running hash 5381, seed and expected serial 0, queue and output empty.
module djb2_mix_serial_check import dmsc_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [ByteW-1:0] name_byte_i,
  input  logic             final_byte_i,
  output logic             empty,
  input  logic             pop,
  output logic [HashW-1:0] serial_value_o,
  output logic             is_match_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [HashW-1:0] cfg_data_i
);

  logic [SeedW-1:0] seed_q;
  logic [HashW-1:0] expected_q;
  logic             accept;
  logic             hand_valid;
  logic [HashW-1:0] hand_hash;
  logic             q_valid, q_pop;
  logic [HashW-1:0] q_hash;

  assign accept = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q     <= '0;
      expected_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSeed:     seed_q     <= cfg_data_i[SeedW-1:0];
        CfgExpected: expected_q <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  dmsc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .name_byte_i  (name_byte_i),
    .final_byte_i (final_byte_i),
    .hand_valid_o (hand_valid),
    .hand_hash_o  (hand_hash)
  );

  dmsc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (hand_valid),
    .wr_data_i (hand_hash),
    .full_o    (full),
    .rd_i      (q_pop),
    .valid_o   (q_valid),
    .rd_data_o (q_hash)
  );

  dmsc_mix u_mix (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_hash_i       (q_hash),
    .q_pop_o        (q_pop),
    .seed_i         (seed_q),
    .expected_i     (expected_q),
    .empty_o        (empty),
    .pop_i          (pop),
    .serial_value_o (serial_value_o),
    .is_match_o     (is_match_o)
  );

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the djb2 name hash and serial check block.
module tb;
  import dmsc_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned SettleCycles  = 24;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned RandPhases    = 6;
  localparam int unsigned PhaseItems    = 155;
  localparam int unsigned DirLen        = 21;

  typedef struct packed {
    logic             last;
    logic [ByteW-1:0] data;
  } name_word_t;

  typedef struct packed {
    logic [HashW-1:0] serial;
    logic             match;
  } serial_word_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             push = 1'b0;
  logic             pop = 1'b0;
  logic [ByteW-1:0] name_byte_i = '0;
  logic             final_byte_i = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic             cfg_idx_i = CfgSeed;
  logic [HashW-1:0] cfg_data_i = '0;
  logic             full;
  logic             empty;
  logic [HashW-1:0] serial_value_o;
  logic             is_match_o;

  djb2_mix_serial_check uut (
    .clk_i,
    .rst_ni,
    .push,
    .full,
    .name_byte_i,
    .final_byte_i,
    .empty,
    .pop,
    .serial_value_o,
    .is_match_o,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i
  );

  // extremes of the byte, single-byte names, multi-byte UTF-8 names, a five-byte mixed name
  name_word_t dir_table [DirLen] = '{
    '{1'b1, 8'h00}, '{1'b1, 8'hFF}, '{1'b1, 8'h7F}, '{1'b1, 8'h80},
    '{1'b0, 8'h41}, '{1'b0, 8'h42}, '{1'b1, 8'h43},
    '{1'b0, 8'hC3}, '{1'b1, 8'hA9},
    '{1'b0, 8'hE2}, '{1'b0, 8'h82}, '{1'b1, 8'hAC},
    '{1'b0, 8'hF0}, '{1'b0, 8'h9F}, '{1'b0, 8'h98}, '{1'b1, 8'h80},
    '{1'b0, 8'h01}, '{1'b0, 8'hFE}, '{1'b0, 8'h55}, '{1'b0, 8'hAA}, '{1'b1, 8'h7F}
  };

  logic [HashW-1:0] djb2_hash = HashStart;
  logic [SeedW-1:0] seed_reg = '0;
  logic [HashW-1:0] expected_reg = '0;
  serial_word_t     pending_serials [$];
  name_word_t       phase_words [$];
  int               mismatches = 0;
  int               burst_left = 0;
  int               stuck_cycles = 0;
  bit               hold_req = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [HashW-1:0] fold_byte(logic [HashW-1:0] h, logic [ByteW-1:0] b);
    return h * 64'd33 + {{(HashW-ByteW){b[ByteW-1]}}, b};
  endfunction

  function automatic logic [HashW-1:0] seal_hash(logic [HashW-1:0] h, logic [SeedW-1:0] seed);
    logic [HashW-1:0] s, w, a, c;
    s = {{HalfW{seed[SeedW-1]}}, seed};
    w = s | (s << HalfW);
    a = (w ^ h) * MixMul;
    a = a ^ (a >> MixShift);
    c = (h ^ a) * MixMul;
    c = c ^ (c >> MixShift);
    return c * MixMul;
  endfunction

  // serial of the name starting at index first of the current phase, from a fresh hash
  function automatic logic [HashW-1:0] planned_serial(int first, logic [SeedW-1:0] seed);
    logic [HashW-1:0] h;
    int i;
    h = HashStart;
    i = first;
    while (!phase_words[i].last) begin
      h = fold_byte(h, phase_words[i].data);
      i++;
    end
    h = fold_byte(h, phase_words[i].data);
    return seal_hash(h, seed);
  endfunction

  function automatic void add_name();
    int len;
    name_word_t wd;
    case ($urandom_range(0, 19))
      0:       len = $urandom_range(21, 64);
      1, 2, 3: len = $urandom_range(7, 20);
      default: len = $urandom_range(1, 6);
    endcase
    for (int i = 0; i < len; i++) begin
      wd.data = $urandom_range(0, 1) ? ByteW'($urandom_range(0, 255))
                                     : ByteW'($urandom_range(8'h20, 8'h7E));
      wd.last = (i == len - 1);
      phase_words.push_back(wd);
    end
  endfunction

  task automatic accept_word(name_word_t wd);
    logic [HashW-1:0] s;
    djb2_hash = fold_byte(djb2_hash, wd.data);
    if (wd.last) begin
      s = seal_hash(djb2_hash, seed_reg);
      pending_serials.push_back(serial_word_t'{serial: s, match: (s == expected_reg)});
      djb2_hash = HashStart;
    end
  endtask

  task automatic send_word(name_word_t wd);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    push <= 1'b1;
    name_byte_i <= wd.data;
    final_byte_i <= wd.last;
    do @(posedge clk_i); while (full);
    accept_word(wd);
    burst_left--;
  endtask

  task automatic write_reg(logic idx, logic [HashW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx == CfgSeed) begin
      seed_reg = data[SeedW-1:0];
    end else begin
      expected_reg = data;
    end
  endtask

  // drain, let the mixer settle, reprogram, then stream the phase
  task automatic run_phase(logic [HashW-1:0] seed_data, logic [HashW-1:0] exp_data,
                           bit hold_now);
    while (pending_serials.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    write_reg(CfgSeed, seed_data);
    write_reg(CfgExpected, exp_data);
    cfg_we_i <= 1'b0;
    // receiver holds off once, as this phase starts to stream in
    if (hold_now) hold_req = 1'b1;
    foreach (phase_words[i]) send_word(phase_words[i]);
    push <= 1'b0;
  endtask

  task automatic check_result();
    serial_word_t want;
    if (pending_serials.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected word: serial %h match %b", $time, serial_value_o, is_match_o);
    end else begin
      want = pending_serials.pop_front();
      if (serial_value_o !== want.serial) begin
        mismatches++;
        $display("%0t: serial_value expected %h actual %h", $time, want.serial, serial_value_o);
      end
      if (is_match_o !== want.match) begin
        mismatches++;
        $display("%0t: is_match expected %b actual %b", $time, want.match, is_match_o);
      end
    end
  endtask

  // result side: stall modes change every so often; one long hold-off on request
  initial begin
    int mode_left;
    int mode;
    int hold_left;
    logic [7:0] pat;
    mode_left = 0;
    mode = 0;
    hold_left = 0;
    pat = '1;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) check_result();
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        pat = 8'($urandom_range(0, 255)) | 8'h01;
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles;
        pop <= 1'b0;
      end else begin
        case (mode)
          0: pop <= 1'b1;
          1: begin
            pat = {pat[6:0], pat[7]};
            pop <= pat[0];
          end
          default: pop <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= WatchdogLimit) begin
      $display("** djb2_mix_serial_check: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [HashW-1:0] seed_data;
    logic [HashW-1:0] exp_data;
    int pick;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // seed 0 with junk above the seed field, which must be dropped
    phase_words = {};
    foreach (dir_table[i]) phase_words.push_back(dir_table[i]);
    run_phase(64'hFFFF_FFFF_0000_0000, '0, 1'b0);

    // most negative seed, expected armed for "ABC"
    phase_words = {};
    phase_words.push_back(name_word_t'{1'b0, 8'h41});
    phase_words.push_back(name_word_t'{1'b0, 8'h42});
    phase_words.push_back(name_word_t'{1'b1, 8'h43});
    run_phase(64'h0000_0000_8000_0000, planned_serial(0, 32'h8000_0000), 1'b0);

    phase_words = {};
    phase_words.push_back(name_word_t'{1'b1, 8'hFF});
    run_phase(64'h0000_0000_7FFF_FFFF, '1, 1'b0);

    phase_words = {};
    phase_words.push_back(name_word_t'{1'b1, 8'h80});
    run_phase('1, planned_serial(0, 32'hFFFF_FFFF), 1'b0);

    for (int p = 0; p < RandPhases; p++) begin
      phase_words = {};
      while (phase_words.size() < PhaseItems) add_name();
      case ($urandom_range(0, 4))
        0:       seed_data = {$urandom, 32'h0000_0000};
        1:       seed_data = {$urandom, 32'hFFFF_FFFF};
        2:       seed_data = {$urandom, 32'h8000_0000};
        3:       seed_data = {$urandom, 32'h7FFF_FFFF};
        default: seed_data = {$urandom, $urandom};
      endcase
      if ($urandom_range(0, 1)) begin
        // arm a match on one name of the phase
        pick = $urandom_range(0, phase_words.size() - 1);
        while (pick > 0 && !phase_words[pick-1].last) pick--;
        exp_data = planned_serial(pick, seed_data[SeedW-1:0]);
      end else begin
        exp_data = {$urandom, $urandom};
      end
      run_phase(seed_data, exp_data, p == 1);
    end

    while (pending_serials.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** djb2_mix_serial_check: PASSED **");
    end else begin
      $display("** djb2_mix_serial_check: FAILED **");
    end
    $finish;
  end

endmodule
